FILE: src/rc_pulse_width_to_duty_core_defines.svh
// Shared assertion macros for the pulse width decoder.
`ifndef RC_PULSE_WIDTH_TO_DUTY_CORE_DEFINES_SVH
`define RC_PULSE_WIDTH_TO_DUTY_CORE_DEFINES_SVH

// Checked outside reset.
`define RPWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked through reset as well.
`define RPWD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rpwd_pkg.sv
package rpwd_pkg;

  localparam int STEP_W = 3;
  localparam int DUTY_W = 8;
  localparam int TICK_W = 16;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;

  localparam logic [1:0] REG_TICKS_LOW  = 2'd0;
  localparam logic [1:0] REG_TICKS_HIGH = 2'd1;
  localparam logic [1:0] REG_DUTY_TOP   = 2'd2;

  localparam logic [TICK_W-1:0] TICKS_LOW_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] TICKS_HIGH_RST = 16'd2000;
  localparam logic [DUTY_W-1:0] DUTY_TOP_RST   = 8'd255;

  localparam logic [STEP_W-1:0] S_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] S_CLAMP = 3'd1;
  localparam logic [STEP_W-1:0] S_MUL   = 3'd2;
  localparam logic [STEP_W-1:0] S_DIV   = 3'd3;
  localparam logic [STEP_W-1:0] S_EMIT  = 3'd4;
  localparam logic [STEP_W-1:0] S_RET   = 3'd5;
  localparam logic [STEP_W-1:0] S_ZERO  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLAMP,
    OP_MUL,
    OP_DIV,
    OP_EMIT,
    OP_ZERO
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BAD_BOUNDS,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic slot_free;
  } scl_ctl_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } scl_stat_t;

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_WAIT:  w = '{op: OP_NOP,   cond: C_NO_START,   target: S_WAIT};
      S_CLAMP: w = '{op: OP_CLAMP, cond: C_BAD_BOUNDS, target: S_ZERO};
      S_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,      target: S_WAIT};
      S_DIV:   w = '{op: OP_DIV,   cond: C_DIV_MORE,   target: S_DIV};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,   target: S_EMIT};
      S_RET:   w = '{op: OP_NOP,   cond: C_ALWAYS,     target: S_WAIT};
      S_ZERO:  w = '{op: OP_ZERO,  cond: C_ALWAYS,     target: S_EMIT};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,     target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

FILE: src/rpwd_scaler.sv
module rpwd_scaler #(
  parameter int W_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rpwd_pkg::scl_ctl_t               ctl,
  input  logic [W_WIDTH-1:0]               width,
  input  logic [rpwd_pkg::TICK_W-1:0]      ticks_low,
  input  logic [rpwd_pkg::TICK_W-1:0]      ticks_high,
  input  logic [rpwd_pkg::DUTY_W-1:0]      duty_top,
  output rpwd_pkg::scl_stat_t              stat,
  output logic [rpwd_pkg::DUTY_W-1:0]      duty
);

  logic [rpwd_pkg::STEP_W-1:0]    step;
  logic [rpwd_pkg::STEP_W-1:0]    step_next;
  rpwd_pkg::uword_t               uw;
  logic                           hit;
  logic                           bad;
  logic [rpwd_pkg::TICK_W-1:0]    off;
  logic [rpwd_pkg::TICK_W-1:0]    span;
  logic [rpwd_pkg::TICK_W-1:0]    rem;
  logic [rpwd_pkg::DUTY_W-1:0]    dq;
  logic [rpwd_pkg::DIV_CNT_W-1:0] cnt;
  logic [rpwd_pkg::TICK_W-1:0]    wc;
  logic [rpwd_pkg::TICK_W+rpwd_pkg::DUTY_W-1:0] prod;
  logic [rpwd_pkg::TICK_W:0]      trial;
  logic [rpwd_pkg::TICK_W:0]      diff;
  logic                           ge;

  assign uw  = rpwd_pkg::ucode(step);
  assign bad = ticks_high <= ticks_low;

  always_comb begin
    if (width > W_WIDTH'(ticks_high)) begin
      wc = ticks_high;
    end else if (width < W_WIDTH'(ticks_low)) begin
      wc = ticks_low;
    end else begin
      wc = width[rpwd_pkg::TICK_W-1:0];
    end
  end

  assign prod  = {{rpwd_pkg::DUTY_W{1'b0}}, off} * {{rpwd_pkg::TICK_W{1'b0}}, duty_top};
  assign trial = {rem, dq[rpwd_pkg::DUTY_W-1]};
  assign diff  = trial - {1'b0, span};
  assign ge    = trial >= {1'b0, span};

  always_comb begin
    case (uw.cond)
      rpwd_pkg::C_NEVER:      hit = 1'b0;
      rpwd_pkg::C_ALWAYS:     hit = 1'b1;
      rpwd_pkg::C_NO_START:   hit = !ctl.start;
      rpwd_pkg::C_BAD_BOUNDS: hit = bad;
      rpwd_pkg::C_DIV_MORE:   hit = cnt != rpwd_pkg::DIV_LAST;
      rpwd_pkg::C_OUT_BUSY:   hit = !ctl.slot_free;
      default:                hit = 1'b0;
    endcase
  end

  assign step_next = hit ? uw.target : step + rpwd_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rpwd_pkg::S_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      rpwd_pkg::OP_CLAMP: begin
        off  <= wc - ticks_low;
        span <= ticks_high - ticks_low;
      end
      rpwd_pkg::OP_MUL: begin
        rem <= prod[rpwd_pkg::TICK_W+rpwd_pkg::DUTY_W-1:rpwd_pkg::DUTY_W];
        dq  <= prod[rpwd_pkg::DUTY_W-1:0];
        cnt <= '0;
      end
      rpwd_pkg::OP_DIV: begin
        rem <= ge ? diff[rpwd_pkg::TICK_W-1:0] : trial[rpwd_pkg::TICK_W-1:0];
        dq  <= {dq[rpwd_pkg::DUTY_W-2:0], ge};
        cnt <= cnt + rpwd_pkg::DIV_CNT_W'(1);
      end
      rpwd_pkg::OP_ZERO: begin
        dq <= '0;
      end
      default: begin
      end
    endcase
  end

  assign stat.busy = step != rpwd_pkg::S_WAIT;
  assign stat.emit = (uw.op == rpwd_pkg::OP_EMIT) && ctl.slot_free;
  assign duty      = dq;

endmodule

FILE: src/rc_pulse_width_to_duty_core.sv
// RC servo pulse width decoder.
// Input channel (in_valid/in_ready, pin_level): one word per timer tick with the
// sampled pin level. The first rising edge arms the block; each rising edge restarts
// a saturating tick counter and each falling edge ends the pulse.
// Output channel (out_valid/out_ready, duty, pulse_ticks): one word per pulse, the
// raw width saturated to 16 bits and the width clamped to the bounds and scaled.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): ticks_low, ticks_high,
// duty_top; write only while idle. Always ready.
// Throughput: ticks that end no pulse go at one word per cycle while the scaler is
// idle. A falling edge hands the width to a microcoded scaler (clamp, one 16x8
// multiply, eight restoring divide steps, emit, return); in_ready is low while it
// runs. With ticks_high not above ticks_low the path is clamp, zero, emit, return.
// Stall: a held result sits in the output register; the scaler waits at its emit
// step while the register is full, so in_ready stays low until the word moves.
// Reset: registers return to 1000/2000/255, the block is disarmed, pin history low.
module rc_pulse_width_to_duty_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [rpwd_pkg::TICK_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pin_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rpwd_pkg::DUTY_W-1:0]     duty,
  output logic [rpwd_pkg::TICK_W-1:0]     pulse_ticks
);

  localparam int WW = (COUNT_WIDTH > rpwd_pkg::TICK_W) ? COUNT_WIDTH : rpwd_pkg::TICK_W;

  logic [rpwd_pkg::TICK_W-1:0] ticks_low;
  logic [rpwd_pkg::TICK_W-1:0] ticks_high;
  logic [rpwd_pkg::DUTY_W-1:0] duty_top;
  logic                        last_level;
  logic                        armed;
  logic                        counting;
  logic [COUNT_WIDTH-1:0]      width_count;
  logic [WW-1:0]               w_ext;
  logic [rpwd_pkg::TICK_W-1:0] ticks_sat;
  logic [rpwd_pkg::DUTY_W-1:0] scl_duty;
  logic                        in_fire;
  logic                        rise;
  logic                        fall;
  rpwd_pkg::scl_ctl_t          ctl;
  rpwd_pkg::scl_stat_t         stat;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign rise      = pin_level && !last_level;
  assign fall      = !pin_level && last_level;
  assign in_ready  = !stat.busy;

  assign ctl.start     = in_fire && fall && armed && counting;
  assign ctl.slot_free = !out_valid || out_ready;

  assign w_ext     = WW'(width_count);
  assign ticks_sat = (w_ext > WW'({rpwd_pkg::TICK_W{1'b1}})) ?
                     {rpwd_pkg::TICK_W{1'b1}} : w_ext[rpwd_pkg::TICK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_low  <= rpwd_pkg::TICKS_LOW_RST;
      ticks_high <= rpwd_pkg::TICKS_HIGH_RST;
      duty_top   <= rpwd_pkg::DUTY_TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpwd_pkg::REG_TICKS_LOW:  ticks_low  <= cfg_data;
        rpwd_pkg::REG_TICKS_HIGH: ticks_high <= cfg_data;
        rpwd_pkg::REG_DUTY_TOP:   duty_top   <= cfg_data[rpwd_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b0;
      armed       <= 1'b0;
      counting    <= 1'b0;
      width_count <= '0;
    end else if (in_fire) begin
      last_level <= pin_level;
      if (rise) begin
        armed       <= 1'b1;
        counting    <= 1'b1;
        width_count <= '0;
      end else begin
        if (counting && !(&width_count)) begin
          width_count <= width_count + COUNT_WIDTH'(1);
        end
        if (fall && armed && counting) begin
          counting <= 1'b0;
        end
      end
    end
  end

  rpwd_scaler #(
    .W_WIDTH(WW)
  ) u_scaler (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .width      (w_ext),
    .ticks_low  (ticks_low),
    .ticks_high (ticks_high),
    .duty_top   (duty_top),
    .stat       (stat),
    .duty       (scl_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      duty        <= scl_duty;
      pulse_ticks <= ticks_sat;
    end
  end

endmodule

FILE: src/rpwd_checker.sv
`include "rc_pulse_width_to_duty_core_defines.svh"

module rpwd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        pin_level,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rpwd_pkg::DUTY_W-1:0] duty,
  input logic [rpwd_pkg::TICK_W-1:0] pulse_ticks
);

  `RPWD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(pulse_ticks), "output word changed while stalled")
  `RPWD_ASSERT_RST(a_rst_clear, rst |=> !out_valid && in_ready, "reset left a word or a busy scaler")
  `RPWD_ASSERT(a_high_no_stall, in_valid && in_ready && pin_level |=> in_ready, "high sample started the scaler")
  `RPWD_ASSERT(a_width_nonzero, out_valid |-> pulse_ticks != '0, "pulse of zero ticks reported")

endmodule

bind rc_pulse_width_to_duty_core rpwd_checker u_rpwd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .pin_level   (pin_level),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .duty        (duty),
  .pulse_ticks (pulse_ticks)
);

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 24;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int LONG_HOLD       = 400;
  localparam int NUM_PHASES      = 6;
  localparam int PHASE_TICKS     = 56;
  localparam int MIN_RAND_PULSES = 16;
  localparam int TIMEOUT_CYCLES  = 200000;
  localparam int DIR_ROWS        = 32;

  localparam logic [1:0]                  REG_UNUSED = 2'd3;
  localparam logic [rpwd_pkg::TICK_W-1:0] TICK_MAX   = '1;

  typedef struct packed {
    logic [rpwd_pkg::DUTY_W-1:0] duty;
    logic [rpwd_pkg::TICK_W-1:0] ticks;
  } pulse_result_t;

  localparam pulse_result_t NO_RESULT = '0;

  typedef enum logic {ROW_PIN, ROW_CFG} row_kind_t;

  typedef enum logic [2:0] {
    MODE_NARROW,
    MODE_FULL_TOP,
    MODE_UNORDERED,
    MODE_UNIT_SPAN,
    MODE_WIDE_RANDOM,
    MODE_CLOSING
  } bounds_mode_t;

  typedef struct {
    row_kind_t                   kind;
    logic                        lvl;
    int                          reps;
    logic [1:0]                  idx;
    logic [rpwd_pkg::TICK_W-1:0] data;
    bit                          typed;
    logic [rpwd_pkg::DUTY_W-1:0] duty;
    logic [rpwd_pkg::TICK_W-1:0] ticks;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index = '0;
  logic [rpwd_pkg::TICK_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        pin_level = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [rpwd_pkg::DUTY_W-1:0] duty;
  logic [rpwd_pkg::TICK_W-1:0] pulse_ticks;

  logic                        prev_level = 1'b0;
  bit                          armed = 1'b0;
  bit                          running = 1'b0;
  logic [rpwd_pkg::TICK_W-1:0] tick_count = '0;
  logic [rpwd_pkg::TICK_W-1:0] low_bound = rpwd_pkg::TICKS_LOW_RST;
  logic [rpwd_pkg::TICK_W-1:0] high_bound = rpwd_pkg::TICKS_HIGH_RST;
  logic [rpwd_pkg::DUTY_W-1:0] duty_scale = rpwd_pkg::DUTY_TOP_RST;

  pulse_result_t pending_pulses[$];

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int ticks_sent = 0;
  int pulses_expected = 0;
  int words_checked = 0;
  int cfg_writes = 0;
  int long_holds = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_PIN, 1'b1,  3, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd0,   16'd3},
    '{ROW_PIN, 1'b1,  1, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd0,   16'd1},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_LOW,  16'd0,    1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_HIGH, 16'hFFFF, 1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_DUTY_TOP,   16'd255,  1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1, 40, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_HIGH, 16'd0,    1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1,  5, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd0,   16'd5},
    '{ROW_CFG, 1'b0,  0, REG_UNUSED,               16'hFFFF, 1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_LOW,  16'd10,   1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_HIGH, 16'd20,   1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_DUTY_TOP,   16'hAB80, 1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1, 15, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b1, 25, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b1,  5, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd0,   16'd5},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_HIGH, 16'd10,   1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1, 15, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd0,   16'd15},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_DUTY_TOP,   16'd0,    1'b0, 8'd0, 16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_TICKS_HIGH, 16'd20,   1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1, 20, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_CFG, 1'b0,  0, rpwd_pkg::REG_DUTY_TOP,   16'd255,  1'b0, 8'd0, 16'd0},
    '{ROW_PIN, 1'b1, 20, '0, 16'd0, 1'b0, 8'd0,   16'd0},
    '{ROW_PIN, 1'b0,  2, '0, 16'd0, 1'b1, 8'd255, 16'd20}
  };

  rc_pulse_width_to_duty_core #(
    .COUNT_WIDTH(16)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty       (duty),
    .pulse_ticks(pulse_ticks)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic logic [rpwd_pkg::DUTY_W-1:0] scale_duty(
      input logic [rpwd_pkg::TICK_W-1:0] w);
    logic [rpwd_pkg::TICK_W-1:0]                  clamped;
    logic [rpwd_pkg::TICK_W+rpwd_pkg::DUTY_W-1:0] product;
    logic [rpwd_pkg::TICK_W+rpwd_pkg::DUTY_W-1:0] quotient;
    if (high_bound <= low_bound) return '0;
    clamped = w;
    if (clamped > high_bound) clamped = high_bound;
    if (clamped < low_bound) clamped = low_bound;
    product = (clamped - low_bound) * duty_scale;
    quotient = product / (high_bound - low_bound);
    return quotient[rpwd_pkg::DUTY_W-1:0];
  endfunction

  task automatic decode_tick(input logic lvl, output bit done, output pulse_result_t res);
    bit rise;
    bit fall;
    rise = lvl && !prev_level;
    fall = !lvl && prev_level;
    prev_level = lvl;
    done = 1'b0;
    res = NO_RESULT;
    if (rise) begin
      armed = 1'b1;
      running = 1'b1;
      tick_count = '0;
    end else begin
      if (running && tick_count != TICK_MAX) tick_count = tick_count + 1'b1;
      if (fall && armed && running) begin
        running = 1'b0;
        done = 1'b1;
        res.duty = scale_duty(tick_count);
        res.ticks = tick_count;
      end
    end
  endtask

  task automatic send_tick(input logic lvl, input bit typed, input pulse_result_t typed_res);
    bit            done;
    pulse_result_t res;
    int            gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    decode_tick(lvl, done, res);
    if (done) begin
      pending_pulses.push_back(typed ? typed_res : res);
      pulses_expected++;
    end
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [rpwd_pkg::TICK_W-1:0] data);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rpwd_pkg::REG_TICKS_LOW:  low_bound = data;
      rpwd_pkg::REG_TICKS_HIGH: high_bound = data;
      rpwd_pkg::REG_DUTY_TOP:   duty_scale = data[rpwd_pkg::DUTY_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [rpwd_pkg::TICK_W-1:0] lo,
                              input logic [rpwd_pkg::TICK_W-1:0] hi,
                              input logic [rpwd_pkg::TICK_W-1:0] top_word);
    cfg_write(rpwd_pkg::REG_TICKS_LOW, lo);
    cfg_write(rpwd_pkg::REG_TICKS_HIGH, hi);
    cfg_write(rpwd_pkg::REG_DUTY_TOP, top_word);
  endtask

  always @(posedge clk) begin
    pulse_result_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (pending_pulses.size() == 0) begin
        flag_mismatch($sformatf("unexpected word duty=%0d ticks=%0d", duty, pulse_ticks));
      end else begin
        want = pending_pulses.pop_front();
        if (duty !== want.duty)
          flag_mismatch($sformatf("duty got %0d want %0d (ticks %0d)",
                                  duty, want.duty, want.ticks));
        if (pulse_ticks !== want.ticks)
          flag_mismatch($sformatf("pulse_ticks got %0d want %0d", pulse_ticks, want.ticks));
      end
    end
  end

  initial begin : sink
    int stall;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        long_holds++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit                          paused;
    int                          phase_ticks;
    int                          run_len;
    int                          gap;
    int                          rand_start;
    pulse_result_t               typed_res;
    logic [rpwd_pkg::TICK_W-1:0] lo;
    bounds_mode_t                mode;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        typed_res.duty = dir_rows[i].duty;
        typed_res.ticks = dir_rows[i].ticks;
        send_tick(dir_rows[i].lvl, dir_rows[i].typed, typed_res);
        repeat (dir_rows[i].reps - 1) send_tick(dir_rows[i].lvl, 1'b0, NO_RESULT);
      end
    end

    rand_start = pulses_expected;
    paused = 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      mode = bounds_mode_t'(phase);
      quiet = (mode == MODE_CLOSING);
      case (mode)
        MODE_NARROW, MODE_CLOSING: begin
          lo = 16'($urandom_range(0, 16));
          program_regs(lo, lo + 16'($urandom_range(1, 32)), 16'($urandom_range(0, 255)));
        end
        MODE_FULL_TOP: begin
          lo = 16'($urandom_range(0, 16));
          program_regs(lo, lo + 16'($urandom_range(1, 32)), 16'd255);
        end
        MODE_UNORDERED: begin
          lo = 16'($urandom_range(0, 40));
          program_regs(lo, 16'($urandom_range(0, lo)), 16'($urandom_range(0, 255)));
        end
        MODE_UNIT_SPAN: begin
          program_regs(16'd0, 16'd1, 16'($urandom_range(0, 255)));
        end
        default: begin
          cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
          program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        end
      endcase
      // hold the sink off while the source keeps pushing words
      if (mode == MODE_FULL_TOP) hold_req = 1'b1;

      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS ||
             (mode == MODE_CLOSING && pulses_expected - rand_start < MIN_RAND_PULSES)) begin
        if (mode == MODE_NARROW && !paused && phase_ticks >= PHASE_TICKS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          run_len = $urandom_range(1, 6);
          repeat (run_len) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
          phase_ticks += run_len;
        end else begin
          run_len = $urandom_range(1, 24);
          gap = $urandom_range(1, 8);
          repeat (run_len) send_tick(1'b1, 1'b0, NO_RESULT);
          repeat (gap) send_tick(1'b0, 1'b0, NO_RESULT);
          phase_ticks += run_len + gap;
        end
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pulses.size() != 0)
      flag_mismatch($sformatf("%0d pulse words never arrived", pending_pulses.size()));

    $display("run: %0d pin ticks, %0d pulse words checked, %0d register writes",
             ticks_sent, words_checked, cfg_writes);
    $display("run: reset bounds, clamping, unordered bounds, masked writes, %0d random %s",
             pulses_expected - rand_start, $sformatf("pulses, %0d long stall", long_holds));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout waiting on the decoder");
    $display("== FAIL ==");
    $finish;
  end

endmodule
